FILE: rtl/tlpq_pkg.sv
// Shared types and constants for the two-level priority queue unit.
package tlpq_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int TOKEN_BITS_DEF = 16;
  localparam int WAIT_W         = 8;

  typedef enum logic [1:0] {
    ACT_PUSH_NORMAL   = 2'd0,
    ACT_PUSH_PRIORITY = 2'd1,
    ACT_REMOVE        = 2'd2,
    ACT_STATUS        = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_REPLY = 1'b1
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    push_n;
    logic    push_p;
    logic    pop_n;
    logic    pop_p;
    status_t code;
  } dp_cmd_t;

  // Queue status from datapath to controller
  typedef struct packed {
    logic n_full;
    logic p_full;
    logic n_empty;
    logic p_empty;
  } dp_stat_t;

endpackage

FILE: rtl/two_level_priority_queue_unit.sv
// Two-level strict-priority token queue unit: top level.
// A transaction accepted at a clock edge has its result strobed on done
// during the following cycle. No new transaction is taken until the result
// has been strobed; busy is high in the result cycle, set by the controller.
// Reset clears the queue pointers and counts; store contents stay undefined
// until written and need no clearing pass. The receiver cannot stall.
module two_level_priority_queue_unit
  import tlpq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action,
  input  logic [TOKEN_BITS-1:0] token,
  output logic                  done,
  output logic [TOKEN_BITS-1:0] served_token,
  output logic [1:0]            status,
  output logic [WAIT_W-1:0]     normal_waiting,
  output logic [WAIT_W-1:0]     priority_waiting
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tlpq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  tlpq_datapath #(.DEPTH(DEPTH), .TOKEN_BITS(TOKEN_BITS)) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .token            (token),
    .stat             (stat),
    .served_token     (served_token),
    .status           (status),
    .normal_waiting   (normal_waiting),
    .priority_waiting (priority_waiting)
  );

endmodule

FILE: rtl/tlpq_fifo.sv
// Circular-buffer token FIFO with a registered read port.
module tlpq_fifo
  import tlpq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int TOKEN_BITS = TOKEN_BITS_DEF,
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  pop,
  input  logic [TOKEN_BITS-1:0] wr_data,
  output logic [TOKEN_BITS-1:0] rd_data,
  output logic [CNT_W-1:0]      count,
  output logic                  full,
  output logic                  empty
);

  logic [TOKEN_BITS-1:0] mem [DEPTH];
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [PTR_W-1:0]      head_next;
  logic [PTR_W-1:0]      tail_next;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  // Advance pointers with wrap at DEPTH
  always_comb begin
    head_next = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
    tail_next = (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wr_data;
    end
    if (pop) begin
      rd_data <= mem[head];
    end
  end

  // Pointer and occupancy registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail_next;
      end
      if (pop) begin
        head <= head_next;
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("count did not advance on push");

endmodule

FILE: rtl/tlpq_datapath.sv
// Datapath: both token queues and the result registers.
module tlpq_datapath
  import tlpq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  input  logic [TOKEN_BITS-1:0] token,
  output dp_stat_t              stat,
  output logic [TOKEN_BITS-1:0] served_token,
  output logic [1:0]            status,
  output logic [WAIT_W-1:0]     normal_waiting,
  output logic [WAIT_W-1:0]     priority_waiting
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [TOKEN_BITS-1:0]   n_rd;
  logic [TOKEN_BITS-1:0]   p_rd;
  logic [CNT_W-1:0]        n_count;
  logic [CNT_W-1:0]        p_count;
  logic [CNT_W+WAIT_W-1:0] n_ext;
  logic [CNT_W+WAIT_W-1:0] p_ext;
  logic                    pop_ok;
  logic                    pop_prio;
  status_t                 status_q;

  tlpq_fifo #(.DEPTH(DEPTH), .TOKEN_BITS(TOKEN_BITS)) u_normal (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd.push_n),
    .pop     (cmd.pop_n),
    .wr_data (token),
    .rd_data (n_rd),
    .count   (n_count),
    .full    (stat.n_full),
    .empty   (stat.n_empty)
  );

  tlpq_fifo #(.DEPTH(DEPTH), .TOKEN_BITS(TOKEN_BITS)) u_priority (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd.push_p),
    .pop     (cmd.pop_p),
    .wr_data (token),
    .rd_data (p_rd),
    .count   (p_count),
    .full    (stat.p_full),
    .empty   (stat.p_empty)
  );

  // Hold the outcome of the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pop_ok   <= cmd.pop_n | cmd.pop_p;
      pop_prio <= cmd.pop_p;
      status_q <= cmd.code;
    end
  end

  // Select the served token; zero unless a remove succeeded
  always_comb begin
    if (!pop_ok) begin
      served_token = '0;
    end else if (pop_prio) begin
      served_token = p_rd;
    end else begin
      served_token = n_rd;
    end
  end

  assign status = status_q;

  // Report waiting counts in their low bits
  assign n_ext            = (CNT_W + WAIT_W)'(n_count);
  assign p_ext            = (CNT_W + WAIT_W)'(p_count);
  assign normal_waiting   = n_ext[WAIT_W-1:0];
  assign priority_waiting = p_ext[WAIT_W-1:0];

endmodule

FILE: rtl/tlpq_ctrl.sv
// Controller: accepts a transaction, issues queue commands, strobes the result.
module tlpq_ctrl
  import tlpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] action,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  state_t  state;
  state_t  state_next;
  action_t act;

  assign act = action_t'(action);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_REPLY;
      S_REPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: decode the action against queue status
  always_comb begin
    cmd      = '0;
    cmd.code = ST_OK;
    busy     = 1'b0;
    done     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (act)
            ACT_PUSH_NORMAL: begin
              if (stat.n_full) cmd.code = ST_FULL;
              else cmd.push_n = 1'b1;
            end
            ACT_PUSH_PRIORITY: begin
              if (stat.p_full) cmd.code = ST_FULL;
              else cmd.push_p = 1'b1;
            end
            ACT_REMOVE: begin
              if (!stat.p_empty) cmd.pop_p = 1'b1;
              else if (!stat.n_empty) cmd.pop_n = 1'b1;
              else cmd.code = ST_EMPTY;
            end
            ACT_STATUS: cmd.code = ST_OK;
            default: cmd.code = ST_OK;
          endcase
        end
      end
      S_REPLY: begin
        busy = 1'b1;
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push_n, cmd.push_p, cmd.pop_n, cmd.pop_p}))
    else $error("more than one queue operation at once");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("accepted transaction not strobed next cycle");
  a_prio_first: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_n |-> stat.p_empty)
    else $error("normal queue served while priority queue holds tokens");

endmodule

FILE: tb/tlpq_checker.sv
// Checker for the two-level priority queue unit: predicts and compares every result.
module tlpq_checker
  import tlpq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                action,
  input  logic [TOKEN_BITS_DEF-1:0] token,
  input  logic                      done,
  input  logic [TOKEN_BITS_DEF-1:0] served_token,
  input  logic [1:0]                status,
  input  logic [WAIT_W-1:0]         normal_waiting,
  input  logic [WAIT_W-1:0]         priority_waiting,
  output int                        mismatches,
  output int                        outstanding
);

  localparam int PTR_W = $clog2(DEPTH_DEF);

  typedef struct {
    logic [TOKEN_BITS_DEF-1:0] served;
    status_t                   code;
    logic [WAIT_W-1:0]         n_wait;
    logic [WAIT_W-1:0]         p_wait;
  } queue_reply_t;

  // Shadow copy of both token FIFOs
  logic [TOKEN_BITS_DEF-1:0] normal_slots   [DEPTH_DEF];
  logic [TOKEN_BITS_DEF-1:0] priority_slots [DEPTH_DEF];
  logic [PTR_W-1:0]          normal_head, priority_head;
  logic [WAIT_W-1:0]         normal_count, priority_count;

  queue_reply_t pending_replies [$];
  int           err_count;

  // Apply one transaction to the shadow queues and return its reply
  task automatic serve_transaction(input action_t act, input logic [TOKEN_BITS_DEF-1:0] tok,
                                   output queue_reply_t rep);
    logic [PTR_W-1:0] slot;
    rep.served = '0;
    rep.code   = ST_OK;
    case (act)
      ACT_PUSH_NORMAL: begin
        if (normal_count >= WAIT_W'(DEPTH_DEF)) begin
          rep.code = ST_FULL;
        end else begin
          slot = normal_head + PTR_W'(normal_count);
          normal_slots[slot] = tok;
          normal_count++;
        end
      end
      ACT_PUSH_PRIORITY: begin
        if (priority_count >= WAIT_W'(DEPTH_DEF)) begin
          rep.code = ST_FULL;
        end else begin
          slot = priority_head + PTR_W'(priority_count);
          priority_slots[slot] = tok;
          priority_count++;
        end
      end
      ACT_REMOVE: begin
        if (priority_count != 0) begin
          rep.served = priority_slots[priority_head];
          priority_head++;
          priority_count--;
        end else if (normal_count != 0) begin
          rep.served = normal_slots[normal_head];
          normal_head++;
          normal_count--;
        end else begin
          rep.code = ST_EMPTY;
        end
      end
      default: ;
    endcase
    rep.n_wait = normal_count;
    rep.p_wait = priority_count;
  endtask

  // Compare results first, then predict the newly accepted transaction
  always @(posedge clk) begin
    queue_reply_t got, want;
    if (rst) begin
      normal_head    = '0;
      priority_head  = '0;
      normal_count   = '0;
      priority_count = '0;
      pending_replies.delete();
      err_count      = 0;
    end else begin
      if (done) begin
        got.served = served_token;
        got.code   = status_t'(status);
        got.n_wait = normal_waiting;
        got.p_wait = priority_waiting;
        if (pending_replies.size() == 0) begin
          if (err_count < 10)
            $display("[%0t] unexpected result: token %h status %0d waits %0d/%0d",
                     $time, got.served, got.code, got.n_wait, got.p_wait);
          err_count++;
        end else begin
          want = pending_replies.pop_front();
          if (got.served !== want.served || got.code !== want.code ||
              got.n_wait !== want.n_wait || got.p_wait !== want.p_wait) begin
            if (err_count < 10) begin
              $display("[%0t] mismatch: expected token %h status %0d waits %0d/%0d",
                       $time, want.served, want.code, want.n_wait, want.p_wait);
              $display("[%0t] mismatch: got token %h status %0d waits %0d/%0d",
                       $time, got.served, got.code, got.n_wait, got.p_wait);
            end
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        serve_transaction(action_t'(action), token, want);
        pending_replies.push_back(want);
      end
    end
    mismatches  <= err_count;
    outstanding <= pending_replies.size();
  end

endmodule

FILE: tb/two_level_priority_queue_unit_test.sv
// Stimulus and verdict for the two-level priority queue unit.
module two_level_priority_queue_unit_test;
  import tlpq_pkg::*;

  typedef enum int {
    MIX_FILL_NORMAL,
    MIX_FILL_PRIORITY,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                action = ACT_STATUS;
  logic [TOKEN_BITS_DEF-1:0] token = '0;
  logic                      done;
  logic [TOKEN_BITS_DEF-1:0] served_token;
  logic [1:0]                status;
  logic [WAIT_W-1:0]         normal_waiting;
  logic [WAIT_W-1:0]         priority_waiting;
  int                        mismatches;
  int                        outstanding;

  always #5 clk = ~clk;

  two_level_priority_queue_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .token(token), .done(done),
    .served_token(served_token), .status(status),
    .normal_waiting(normal_waiting), .priority_waiting(priority_waiting)
  );

  tlpq_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .token(token), .done(done),
    .served_token(served_token), .status(status),
    .normal_waiting(normal_waiting), .priority_waiting(priority_waiting),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Present one transaction and hold it until accepted
  task automatic send_item(input action_t act, input logic [TOKEN_BITS_DEF-1:0] tok);
    @(negedge clk);
    start  <= 1'b1;
    action <= act;
    token  <= tok;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a number of cycles
  task automatic idle_gap(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic action_t pick_action(input traffic_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL_NORMAL:   return (roll < 95) ? ACT_PUSH_NORMAL : action_t'($urandom_range(1, 3));
      MIX_FILL_PRIORITY: return (roll < 95) ? ACT_PUSH_PRIORITY : action_t'($urandom_range(0, 3));
      MIX_DRAIN:         return (roll < 90) ? ACT_REMOVE : action_t'($urandom_range(0, 3));
      default:           return action_t'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [TOKEN_BITS_DEF-1:0] pick_token();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return TOKEN_BITS_DEF'($urandom);
  endfunction

  // Run one traffic segment in random bursts, most followed by a random idle gap
  task automatic run_segment(input traffic_mix_t mix, input int items);
    int left, burst;
    left = items;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_item(pick_action(mix), pick_token());
      left -= burst;
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty queues, extreme tokens, priority ordering, ignored tokens
    send_item(ACT_STATUS, 16'h0000);
    send_item(ACT_REMOVE, 16'h0000);
    send_item(ACT_PUSH_NORMAL, 16'h0000);
    send_item(ACT_PUSH_NORMAL, 16'hFFFF);
    send_item(ACT_PUSH_PRIORITY, 16'hA5A5);
    send_item(ACT_PUSH_PRIORITY, 16'h5A5A);
    send_item(ACT_STATUS, 16'hFFFF);
    send_item(ACT_REMOVE, 16'hFFFF);
    send_item(ACT_PUSH_NORMAL, 16'h1234);
    send_item(ACT_REMOVE, 16'h0000);
    send_item(ACT_REMOVE, 16'h0000);
    send_item(ACT_PUSH_PRIORITY, 16'hFFFF);
    send_item(ACT_PUSH_PRIORITY, 16'h0000);
    send_item(ACT_REMOVE, 16'h0000);
    send_item(ACT_REMOVE, 16'h8001);
    send_item(ACT_REMOVE, 16'h0000);
    send_item(ACT_REMOVE, 16'hFFFF);
    send_item(ACT_REMOVE, 16'hFFFF);
    send_item(ACT_STATUS, 16'h7FFE);
    idle_gap(3);

    // Random: fill each queue past full, drain both past empty, then mixed traffic
    run_segment(MIX_FILL_NORMAL, 160);
    run_segment(MIX_FILL_PRIORITY, 160);
    run_segment(MIX_DRAIN, 300);
    run_segment(MIX_EVEN, 130);

    // Drain the remaining results
    @(negedge clk);
    start <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (outstanding != 0 && wait_cycles < 1000);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule
